// ===== rtl/hdr_reinhard_gamma_tonemap_assert.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the HDR tone mapper
// Clocked property checks that compile to nothing in synthesis.
// ---------------------------------------------------------------------------
`ifndef HDR_REINHARD_GAMMA_TONEMAP_ASSERT_SVH
`define HDR_REINHARD_GAMMA_TONEMAP_ASSERT_SVH

`ifndef SYNTHESIS
`define RGT_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define RGT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RGT_ASSERT(lbl, clk, rst, prop, msg)
`define RGT_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// ===== rtl/rgt_pkg.sv =====
// ---------------------------------------------------------------------------
// Tone mapper package
// Pixel types, register indexes, mode codes and the gamma search table.
// ---------------------------------------------------------------------------
package rgt_pkg;

  typedef struct packed {
    logic [31:0] red_in;
    logic [31:0] green_in;
    logic [31:0] blue_in;
    logic [31:0] alpha_in;
    logic        last_in;
  } pix_in_t;

  typedef struct packed {
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic [7:0] alpha_out;
    logic       last_out;
  } pix_out_t;

  localparam logic [1:0] REG_EXPOSURE = 2'd0;
  localparam logic [1:0] REG_GAMMA    = 2'd1;
  localparam logic [1:0] REG_CHANNELS = 2'd2;

  localparam logic [2:0] CH_NONE   = 3'd0;
  localparam logic [2:0] CH_GREY   = 3'd1;
  localparam logic [2:0] CH_BLACK  = 3'd2;
  localparam logic [2:0] CH_OPAQUE = 3'd3;
  localparam logic [2:0] CH_RGBA   = 3'd4;

  localparam logic [15:0] EXPOSURE_RESET = 16'd256;
  localparam logic [15:0] GAMMA_RESET    = 16'd9011;
  localparam logic [2:0]  CHANNELS_RESET = CH_RGBA;

  // Multiply, divider, log2 and gamma search stages of one color channel.
  localparam int CH_LAT = 52;

  typedef logic [18:0] diff_tab_t [256];

  // Fixed point log2 in Q5.16 by repeated squaring of the mantissa.
  function automatic longint unsigned log2_q16_const(longint unsigned v_arg);
    longint unsigned v;
    longint unsigned m;
    longint unsigned frac;
    int e;
    int i;
    v = (v_arg == 0) ? 1 : v_arg;
    e = 0;
    for (i = 0; i < 16; i++) begin
      if ((v >> (i + 1)) != 0) e = i + 1;
    end
    m = v << (16 - e);
    frac = 0;
    for (i = 0; i < 16; i++) begin
      m = (m * m) >> 16;
      frac = frac << 1;
      if (m >= 64'h20000) begin
        frac = frac | 1;
        m = m >> 1;
      end
    end
    return (longint'(e) << 16) | frac;
  endfunction

  // Entry k holds log2(255) - log2(k), floored at zero.
  function automatic diff_tab_t build_diff_tab();
    diff_tab_t tab;
    longint unsigned l255;
    longint unsigned lk;
    int k;
    l255 = log2_q16_const(255);
    for (k = 0; k < 256; k++) begin
      lk = log2_q16_const(longint'(k));
      tab[k] = (lk < l255) ? 19'(l255 - lk) : 19'd0;
    end
    return tab;
  endfunction

  localparam diff_tab_t DIFF_TAB = build_diff_tab();

endpackage

// ===== rtl/rgt_recip_div.sv =====
// ---------------------------------------------------------------------------
// Reinhard compression divider
// Pipelined restoring division t = floor(x * 2^16 / (x + 2^16)), one bit a stage.
// ---------------------------------------------------------------------------
module rgt_recip_div (
  input  logic        clk,
  input  logic        en,
  input  logic [39:0] x,
  output logic [15:0] t
);
  import rgt_pkg::*;

  logic [40:0] rem [17];
  logic [40:0] den [17];
  logic [15:0] quo [17];

  // The low half of the dividend is zero, so the first partial remainder is x.
  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= {1'b0, x};
      den[0] <= {1'b0, x} + 41'h10000;
      quo[0] <= '0;
    end
  end

  for (genvar i = 0; i < 16; i++) begin : g_step
    logic [41:0] r2;
    logic [41:0] sub;
    logic        ge;
    assign r2  = {rem[i], 1'b0};
    assign sub = r2 - {1'b0, den[i]};
    assign ge  = (r2 >= {1'b0, den[i]});
    always_ff @(posedge clk) begin
      if (en) begin
        rem[i+1] <= ge ? sub[40:0] : r2[40:0];
        den[i+1] <= den[i];
        quo[i+1] <= {quo[i][14:0], ge};
      end
    end
  end

  assign t = quo[16];

endmodule

// ===== rtl/rgt_log2.sv =====
// ---------------------------------------------------------------------------
// Pipelined log2
// Leading one detect, then one mantissa squaring per stage for 16 fraction bits.
// ---------------------------------------------------------------------------
module rgt_log2 (
  input  logic        clk,
  input  logic        en,
  input  logic [15:0] t,
  output logic [19:0] lg,
  output logic        zero
);
  import rgt_pkg::*;

  logic [16:0] man  [17];
  logic [3:0]  expo [17];
  logic [15:0] frac [17];
  logic        zq   [17];

  logic [15:0] v;
  logic [3:0]  e0;
  logic [16:0] m0;

  always_comb begin
    v  = (t == 16'd0) ? 16'd1 : t;
    e0 = '0;
    for (int i = 1; i < 16; i++) begin
      if (v[i]) e0 = 4'(i);
    end
    m0 = 17'(v) << (5'd16 - {1'b0, e0});
  end

  always_ff @(posedge clk) begin
    if (en) begin
      man[0]  <= m0;
      expo[0] <= e0;
      frac[0] <= '0;
      zq[0]   <= (t == 16'd0);
    end
  end

  for (genvar i = 0; i < 16; i++) begin : g_sq
    logic [33:0] sq;
    logic [17:0] s;
    assign sq = man[i] * man[i];
    assign s  = sq[33:16];
    always_ff @(posedge clk) begin
      if (en) begin
        man[i+1]  <= s[17] ? s[17:1] : s[16:0];
        frac[i+1] <= {frac[i][14:0], s[17]};
        expo[i+1] <= expo[i];
        zq[i+1]   <= zq[i];
      end
    end
  end

  assign lg   = {expo[16], frac[16]};
  assign zero = zq[16];

endmodule

// ===== rtl/rgt_gamma_search.sv =====
// ---------------------------------------------------------------------------
// Gamma output search
// Binary search for the largest 8-bit code whose gamma curve does not exceed the tone
// value, compared in the log domain; two stages per output bit.
// ---------------------------------------------------------------------------
module rgt_gamma_search (
  input  logic        clk,
  input  logic        en,
  input  logic [15:0] gamma,
  input  logic [19:0] lg,
  input  logic        zero,
  output logic [7:0]  k
);
  import rgt_pkg::*;

  localparam logic [20:0] LG_FULL = 21'h100000;

  logic [32:0] need0;
  logic        zero0;

  logic [34:0] a_prod [8];
  logic [7:0]  a_cand [8];
  logic [7:0]  a_k    [8];
  logic [32:0] a_need [8];
  logic        a_zero [8];
  logic [7:0]  b_k    [8];
  logic [32:0] b_need [8];
  logic        b_zero [8];

  always_ff @(posedge clk) begin
    if (en) begin
      need0 <= {LG_FULL - {1'b0, lg}, 12'b0};
      zero0 <= zero;
    end
  end

  for (genvar j = 0; j < 8; j++) begin : g_bit
    logic [7:0]  k_in;
    logic [32:0] need_in;
    logic        zero_in;
    logic [7:0]  cand;
    logic [34:0] prod;
    if (j == 0) begin : g_first
      assign k_in    = '0;
      assign need_in = need0;
      assign zero_in = zero0;
    end else begin : g_next
      assign k_in    = b_k[j-1];
      assign need_in = b_need[j-1];
      assign zero_in = b_zero[j-1];
    end
    assign cand = k_in | (8'h80 >> j);
    assign prod = gamma * DIFF_TAB[cand];
    always_ff @(posedge clk) begin
      if (en) begin
        a_prod[j] <= prod;
        a_cand[j] <= cand;
        a_k[j]    <= k_in;
        a_need[j] <= need_in;
        a_zero[j] <= zero_in;
        b_k[j]    <= (a_prod[j] >= {2'b0, a_need[j]}) ? a_cand[j] : a_k[j];
        b_need[j] <= a_need[j];
        b_zero[j] <= a_zero[j];
      end
    end
  end

  // A zero tone value maps to black whatever the search found.
  assign k = b_zero[7] ? 8'd0 : b_k[7];

endmodule

// ===== rtl/rgt_channel.sv =====
// ---------------------------------------------------------------------------
// Tone mapper color channel
// Exposure multiply, Reinhard divider, log2 and gamma search in one pipeline.
// ---------------------------------------------------------------------------
module rgt_channel (
  input  logic        clk,
  input  logic        en,
  input  logic [31:0] c,
  input  logic [15:0] exposure,
  input  logic [15:0] gamma,
  output logic [7:0]  k
);
  import rgt_pkg::*;

  logic [47:0] prod;
  logic [39:0] x;
  logic [15:0] t;
  logic [19:0] lg;
  logic        zero;

  assign prod = c * exposure;

  always_ff @(posedge clk) begin
    if (en) x <= prod[47:8];
  end

  rgt_recip_div u_div (.clk(clk), .en(en), .x(x), .t(t));

  rgt_log2 u_log (.clk(clk), .en(en), .t(t), .lg(lg), .zero(zero));

  rgt_gamma_search u_search (
    .clk(clk), .en(en), .gamma(gamma), .lg(lg), .zero(zero), .k(k)
  );

endmodule

// ===== rtl/hdr_reinhard_gamma_tonemap.sv =====
// Throughput: one pixel per cycle; the 52-stage channel pipeline takes a new pixel
// every cycle while a one-entry skid buffer behind it has room.
// Reset (rst, synchronous) clears all valid bits, empties output and skid buffer
// and loads exposure 1.0, gamma 2.2 and four-channel mode.
// ---------------------------------------------------------------------------
// HDR Reinhard tone mapper with gamma correction
// Maps Q16.16 RGBA pixels to 8-bit RGBA, one pixel per cycle while the skid buffer has room.
// ---------------------------------------------------------------------------
`include "hdr_reinhard_gamma_tonemap_assert.svh"

module hdr_reinhard_gamma_tonemap (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  rgt_pkg::pix_in_t in_pix,
  output logic             out_valid,
  input  logic             out_stall,
  output rgt_pkg::pix_out_t out_pix,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [1:0]       cfg_index,
  input  logic [15:0]      cfg_data
);
  import rgt_pkg::*;

  logic [15:0] exposure_gain;
  logic [15:0] gamma_value;
  logic [2:0]  channel_count;

  logic        en;
  logic        skid_valid;
  pix_out_t    skid_pix;

  logic [31:0] red_sel;
  logic [31:0] green_sel;
  logic [31:0] blue_sel;
  logic [39:0] alpha_prod;
  logic [7:0]  alpha8;

  logic        side_valid [CH_LAT];
  logic        side_last  [CH_LAT];
  logic [7:0]  side_alpha [CH_LAT];

  logic [7:0]  red_k;
  logic [7:0]  green_k;
  logic [7:0]  blue_k;
  pix_out_t    stage_pix;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      exposure_gain <= EXPOSURE_RESET;
      gamma_value   <= GAMMA_RESET;
      channel_count <= CHANNELS_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_EXPOSURE: exposure_gain <= cfg_data;
        REG_GAMMA:    gamma_value   <= cfg_data;
        REG_CHANNELS: channel_count <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  // The pipeline moves whenever the skid buffer is free.
  assign en       = !skid_valid;
  assign in_stall = skid_valid;

  always_comb begin
    case (channel_count) inside
      CH_GREY: begin
        red_sel   = in_pix.red_in;
        green_sel = in_pix.red_in;
        blue_sel  = in_pix.red_in;
      end
      CH_NONE, CH_BLACK: begin
        red_sel   = '0;
        green_sel = '0;
        blue_sel  = '0;
      end
      default: begin
        red_sel   = in_pix.red_in;
        green_sel = in_pix.green_in;
        blue_sel  = in_pix.blue_in;
      end
    endcase
    alpha_prod = {in_pix.alpha_in, 8'b0} - {8'b0, in_pix.alpha_in};
    if (channel_count >= CH_RGBA) begin
      alpha8 = (|alpha_prod[39:24]) ? 8'hFF : alpha_prod[23:16];
    end else begin
      alpha8 = 8'hFF;
    end
  end

  rgt_channel u_red (
    .clk(clk), .en(en), .c(red_sel), .exposure(exposure_gain),
    .gamma(gamma_value), .k(red_k)
  );
  rgt_channel u_green (
    .clk(clk), .en(en), .c(green_sel), .exposure(exposure_gain),
    .gamma(gamma_value), .k(green_k)
  );
  rgt_channel u_blue (
    .clk(clk), .en(en), .c(blue_sel), .exposure(exposure_gain),
    .gamma(gamma_value), .k(blue_k)
  );

  // Valid, last and alpha ride alongside the color channels.
  always_ff @(posedge clk) begin
    if (rst) begin
      side_valid[0] <= 1'b0;
    end else if (en) begin
      side_valid[0] <= in_valid;
    end
    if (en) begin
      side_last[0]  <= in_pix.last_in;
      side_alpha[0] <= alpha8;
    end
  end

  for (genvar i = 1; i < CH_LAT; i++) begin : g_side
    always_ff @(posedge clk) begin
      if (rst) begin
        side_valid[i] <= 1'b0;
      end else if (en) begin
        side_valid[i] <= side_valid[i-1];
      end
      if (en) begin
        side_last[i]  <= side_last[i-1];
        side_alpha[i] <= side_alpha[i-1];
      end
    end
  end

  always_comb begin
    stage_pix.red_out   = red_k;
    stage_pix.green_out = green_k;
    stage_pix.blue_out  = blue_k;
    stage_pix.alpha_out = side_alpha[CH_LAT-1];
    stage_pix.last_out  = side_last[CH_LAT-1];
  end

  // Output register with a skid entry that catches a pixel leaving the
  // pipeline while the output is stalled.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || !out_stall) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid  <= side_valid[CH_LAT-1];
      end
    end else if (en && side_valid[CH_LAT-1]) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || !out_stall) begin
      out_pix <= skid_valid ? skid_pix : stage_pix;
    end else if (en) begin
      skid_pix <= stage_pix;
    end
  end

  `RGT_ASSERT(a_skid_needs_out, clk, rst, skid_valid |-> out_valid, "skid full with empty output")
  `RGT_ASSERT(a_skid_on_stall, clk, rst, $rose(skid_valid) |-> $past(out_stall), "skid filled without a stall")
  `RGT_ASSERT(a_skid_holds, clk, rst, (skid_valid && out_stall) |=> skid_valid, "skid entry lost under stall")
  `RGT_ASSERT_ALWAYS(a_reset_clears, clk, rst |=> (!out_valid && !skid_valid), "reset left a result pending")

endmodule

// ===== verif/tb_hdr_reinhard_gamma_tonemap.sv =====
// ---------------------------------------------------------------------------
// Testbench for the HDR Reinhard tone mapper
// Drives pixel requests under several exposure, gamma and channel settings,
// predicts every output pixel in fixed point and checks the results in order.
// ---------------------------------------------------------------------------
module tb_hdr_reinhard_gamma_tonemap;
  import rgt_pkg::*;

  localparam logic [1:0] REG_UNUSED = 2'd3;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 60;

  // Fixed point log2 in Q5.16 for 1..131071; zero is treated as one.
  function automatic logic [20:0] log2_fix(logic [16:0] v_arg);
    logic [16:0] v;
    logic [63:0] mant;
    logic [15:0] frac;
    int lead;
    v = (v_arg == 0) ? 17'd1 : v_arg;
    lead = 0;
    for (int i = 16; i >= 0; i--) begin
      if (v[i] && lead == 0) lead = i;
    end
    mant = 64'(v) << (16 - lead);
    frac = '0;
    for (int i = 0; i < 16; i++) begin
      mant = (mant * mant) >> 16;
      frac = {frac[14:0], 1'b0};
      if (mant >= 64'h20000) begin
        frac[0] = 1'b1;
        mant = mant >> 1;
      end
    end
    return {5'(lead), frac};
  endfunction

  class tonemap_scoreboard;
    logic [15:0] exposure;
    logic [15:0] gamma;
    logic [2:0] channels;
    logic [20:0] log_gap [256];
    pix_out_t expected_pix [$];
    int mismatches;

    function new();
      logic [20:0] l255;
      logic [20:0] lk;
      exposure = 16'd256;
      gamma = 16'd9011;
      channels = CH_RGBA;
      mismatches = 0;
      l255 = log2_fix(17'd255);
      for (int k = 0; k < 256; k++) begin
        lk = log2_fix(17'(k));
        log_gap[k] = (lk < l255) ? l255 - lk : '0;
      end
    endfunction

    function void write_reg(logic [1:0] idx, logic [15:0] data);
      case (idx)
        REG_EXPOSURE: exposure = data;
        REG_GAMMA: gamma = data;
        REG_CHANNELS: channels = data[2:0];
        default: ;
      endcase
    endfunction

    // Largest code k with (k/255)^gamma <= t, judged on log2 values.
    function logic [7:0] tone_channel(logic [31:0] c);
      logic [63:0] scaled;
      logic [63:0] tone;
      logic [63:0] need;
      logic [7:0] code;
      logic [7:0] cand;
      scaled = (64'(c) * 64'(exposure)) >> 8;
      tone = (scaled << 16) / (scaled + 64'd65536);
      if (tone == 0) return 8'd0;
      need = (64'(21'd16 << 16) - 64'(log2_fix(17'(tone)))) << 12;
      code = '0;
      for (int b = 7; b >= 0; b--) begin
        cand = code | (8'd1 << b);
        if (64'(gamma) * 64'(log_gap[cand]) >= need) code = cand;
      end
      return code;
    endfunction

    function void note_request(pix_in_t p);
      pix_out_t e;
      logic [31:0] r;
      logic [31:0] g;
      logic [31:0] b;
      logic [63:0] a;
      r = p.red_in;
      g = p.green_in;
      b = p.blue_in;
      if (channels == CH_GREY) begin
        g = r;
        b = r;
      end else if (channels < CH_OPAQUE) begin
        r = '0;
        g = '0;
        b = '0;
      end
      if (channels >= CH_RGBA) begin
        a = (64'(p.alpha_in) * 64'd255) >> 16;
        e.alpha_out = (a > 255) ? 8'd255 : a[7:0];
      end else begin
        e.alpha_out = 8'd255;
      end
      e.red_out = tone_channel(r);
      e.green_out = tone_channel(g);
      e.blue_out = tone_channel(b);
      e.last_out = p.last_in;
      expected_pix = {expected_pix, e};
    endfunction

    function void check_result(pix_out_t got);
      pix_out_t e;
      if (expected_pix.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected output pixel %h", got);
        return;
      end
      e = expected_pix.pop_front();
      if (got.red_out !== e.red_out || got.green_out !== e.green_out ||
          got.blue_out !== e.blue_out || got.alpha_out !== e.alpha_out ||
          got.last_out !== e.last_out) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Pixel mismatch: expected rgbal %0d %0d %0d %0d %0d, got %0d %0d %0d %0d %0d",
                   e.red_out, e.green_out, e.blue_out, e.alpha_out, e.last_out,
                   got.red_out, got.green_out, got.blue_out, got.alpha_out, got.last_out);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  pix_in_t in_pix = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  pix_out_t out_pix;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;

  tonemap_scoreboard sb = new();
  bit quiet = 1'b0;
  bit pressure_go = 1'b0;
  bit pressure_done = 1'b0;
  int hold_left = 0;
  int idle_cycles = 0;

  hdr_reinhard_gamma_tonemap uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_pix(in_pix),
    .out_valid(out_valid), .out_stall(out_stall), .out_pix(out_pix),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  // Receiver: mostly ready, short and occasional long stalls, one long hold-off.
  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (pressure_go && !pressure_done) begin
      pressure_done = 1'b1;
      hold_left = 200;
      out_stall <= 1'b1;
    end else if (quiet) begin
      out_stall <= 1'b0;
    end else begin
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4: begin
          hold_left = $urandom_range(0, 3);
          out_stall <= 1'b1;
        end
        5: begin
          hold_left = $urandom_range(10, 40);
          out_stall <= 1'b1;
        end
        default: out_stall <= 1'b0;
      endcase
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_result(out_pix);
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 9))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      2, 3: return 32'($urandom_range(0, 32'h2FFFF));
      4: return 32'd1 << $urandom_range(0, 31);
      default: return $urandom;
    endcase
  endfunction

  // Called at a falling edge; returns at a falling edge.
  task automatic send_pixel(pix_in_t p);
    int gap;
    in_valid <= 1'b1;
    in_pix <= p;
    do @(posedge clk); while (in_stall);
    sb.note_request(p);
    @(negedge clk);
    if (quiet) gap = 0;
    else case ($urandom_range(0, 19))
      0, 1, 2, 3, 4, 5: gap = $urandom_range(1, 3);
      6: gap = $urandom_range(10, 40);
      default: gap = 0;
    endcase
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (sb.expected_pix.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_cfg(logic [1:0] idx, logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, data);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_directed(logic [31:0] r, logic [31:0] g, logic [31:0] b,
                               logic [31:0] a, logic l);
    pix_in_t p;
    p.red_in = r;
    p.green_in = g;
    p.blue_in = b;
    p.alpha_in = a;
    p.last_in = l;
    send_pixel(p);
  endtask

  task automatic send_random(int count);
    pix_in_t p;
    for (int i = 0; i < count; i++) begin
      p.red_in = rand_word();
      p.green_in = rand_word();
      p.blue_in = rand_word();
      p.alpha_in = ($urandom_range(0, 1) == 1) ? 32'($urandom_range(0, 32'h11000))
                                                : rand_word();
      p.last_in = ($urandom_range(0, 7) == 0);
      send_pixel(p);
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset settings: extremes of every field, unity and alpha around 1.0.
    send_directed(32'd0, 32'd0, 32'd0, 32'd0, 1'b0);
    send_directed(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
    send_directed(32'h0001_0000, 32'h0000_8000, 32'h0004_0000, 32'h0001_0000, 1'b0);
    send_directed(32'd1, 32'd2, 32'd255, 32'h0001_0101, 1'b0);
    send_directed(32'h0000_0100, 32'h00FF_0000, 32'h8000_0000, 32'h0000_FFFF, 1'b1);
    send_directed(32'h5555_5555, 32'hAAAA_AAAA, 32'h0000_0001, 32'h0000_0101, 1'b0);
    send_directed(32'h0000_4000, 32'h0002_0000, 32'h7FFF_FFFF, 32'd1, 1'b1);
    send_random(95);
    wait_idle();

    // Bright exposure, opaque mode; the receiver holds off while requests
    // keep coming back to back, so the pipeline fills and stalls its input.
    write_cfg(REG_EXPOSURE, 16'hFFFF);
    write_cfg(REG_CHANNELS, {13'h0, CH_OPAQUE});
    quiet = 1'b1;
    pressure_go = 1'b1;
    send_random(100);
    wait_idle();
    quiet = 1'b0;

    // Dimmest nonzero exposure, smallest nonzero gamma, grey mode.
    write_cfg(REG_EXPOSURE, 16'd1);
    write_cfg(REG_GAMMA, 16'd1);
    write_cfg(REG_CHANNELS, {13'h1FFF, CH_GREY});
    send_random(95);
    wait_idle();

    // Zero exposure, largest gamma, black mode, no idling at all.
    quiet = 1'b1;
    write_cfg(REG_EXPOSURE, 16'd0);
    write_cfg(REG_GAMMA, 16'hFFFF);
    write_cfg(REG_CHANNELS, {13'h0, CH_BLACK});
    send_random(95);
    wait_idle();
    quiet = 1'b0;

    // Zero gamma and a channel count of zero.
    write_cfg(REG_EXPOSURE, 16'd128);
    write_cfg(REG_GAMMA, 16'd0);
    write_cfg(REG_CHANNELS, {13'h0, CH_NONE});
    send_random(95);
    wait_idle();

    // Counts above four behave as four; the upper data bits are dropped.
    write_cfg(REG_EXPOSURE, 16'($urandom_range(1, 16'hFFFF)));
    write_cfg(REG_GAMMA, 16'd4096);
    write_cfg(REG_CHANNELS, {13'($urandom), 3'd5});
    send_random(95);
    wait_idle();

    // A write to the spare index must leave every register alone.
    write_cfg(REG_EXPOSURE, 16'd2048);
    write_cfg(REG_GAMMA, 16'd9011);
    write_cfg(REG_CHANNELS, {13'h0, 3'd7});
    write_cfg(REG_UNUSED, 16'($urandom));
    send_random(95);
    wait_idle();

    write_cfg(REG_EXPOSURE, 16'd256);
    write_cfg(REG_GAMMA, 16'($urandom_range(1, 16'hFFFF)));
    write_cfg(REG_CHANNELS, {13'h0, 3'd6});
    send_random(95);
    wait_idle();

    write_cfg(REG_EXPOSURE, 16'($urandom));
    write_cfg(REG_GAMMA, 16'($urandom_range(2048, 16384)));
    write_cfg(REG_CHANNELS, {13'h0, CH_RGBA});
    send_random(80);
    wait_idle();

    if (sb.mismatches == 0 && sb.expected_pix.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule

// ===== hdr_reinhard_gamma_tonemap.f =====
+incdir+rtl
rtl/rgt_pkg.sv
rtl/rgt_recip_div.sv
rtl/rgt_log2.sv
rtl/rgt_gamma_search.sv
rtl/rgt_channel.sv
rtl/hdr_reinhard_gamma_tonemap.sv
verif/tb_hdr_reinhard_gamma_tonemap.sv
